/* hw/rtl/mssd_pkg.sv */
// shared types, constants and segment table for the seven-segment driver
package mssd_pkg;

  localparam int unsigned NUM_W     = 32;
  localparam int unsigned STEP_W    = $clog2(NUM_W);
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 4;
  localparam int unsigned SEL_W     = 4;
  localparam int unsigned OUT_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_COMMON_CATHODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT    = 1'b1;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REFRESH = 1'b1;

  typedef logic [3:0] digit_t;
  typedef logic [6:0] seg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN
  } state_e;

  // 10^n - 1, used at elaboration only
  function automatic logic [63:0] pow10_m1(input int unsigned n);
    logic [63:0] acc;
    acc = 64'd1;
    for (int unsigned k = 0; k < n; k++) begin
      acc = acc * 64'd10;
    end
    return acc - 64'd1;
  endfunction

  // segments a..g with a in bit 6, common-cathode levels
  function automatic seg_t seg_of(input digit_t d);
    seg_t s;
    case (d)
      4'd0:    s = 7'h7E;
      4'd1:    s = 7'h30;
      4'd2:    s = 7'h6D;
      4'd3:    s = 7'h79;
      4'd4:    s = 7'h33;
      4'd5:    s = 7'h5B;
      4'd6:    s = 7'h5F;
      4'd7:    s = 7'h70;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h7B;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/mssd_dabble.sv */
// serial binary to bcd converter, one shift-and-correct step per cycle
module mssd_dabble #(
  parameter int unsigned MAX_DIGITS = 9
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [mssd_pkg::NUM_W-1:0]            value_i,
  output logic                                  busy_o,
  output logic                                  done_o,
  output mssd_pkg::digit_t [MAX_DIGITS-1:0]     digits_o
);
  import mssd_pkg::*;

  digit_t [MAX_DIGITS-1:0] bcd_q, bcd_d, bcd_adj;
  logic [NUM_W-1:0]        bin_q, bin_d;
  logic [STEP_W-1:0]       cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic                    last_step;

  assign last_step = busy_q && (cnt_q == STEP_W'(NUM_W - 1));

  always_comb begin
    // add three to every digit that would pass nine after the shift
    for (int unsigned j = 0; j < MAX_DIGITS; j++) begin
      bcd_adj[j] = (bcd_q[j] >= 4'd5) ? bcd_q[j] + 4'd3 : bcd_q[j];
    end
    bcd_d  = bcd_q;
    bin_d  = bin_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      bcd_d  = '0;
      bin_d  = value_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d  = {bcd_adj[MAX_DIGITS-1:0]} << 1 | (MAX_DIGITS*4)'(bin_q[NUM_W-1]);
      bin_d  = bin_q << 1;
      cnt_d  = cnt_q + STEP_W'(1);
      busy_d = !last_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      bcd_q  <= bcd_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
  end

  assign busy_o   = busy_q;
  assign done_o   = last_step;
  assign digits_o = bcd_q;

  // a start only arrives while the unit is free
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("converter restarted while busy");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q) else $error("converter still busy after last step");

  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && !start_i) |=> !busy_q) else $error("converter woke without start");

endmodule

/* hw/rtl/multiplexed_seven_segment_driver_core.sv */
// top level: request decode, scan sequencer, output register and config registers
// a load takes the request, then runs one serial conversion step per input bit
// in the shift-and-correct unit; no request is accepted then, but config writes are
// a refresh gives one digit per cycle while the output is taken, min(digit_count,
// MAX_DIGITS) results, and is ready again as soon as the last one is registered
// reset clears the stored digits to zero, the overflow flag, and the config registers
// to common cathode with four digits
module multiplexed_seven_segment_driver_core #(
  parameter int unsigned MAX_DIGITS = 9
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave side, tdata: number[31:0]; tuser: kind
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [mssd_pkg::NUM_W-1:0]         s_axis_tdata,
  input  logic                               s_axis_tuser,
  // master side, tdata: segment_levels[6:0], digit_select[10:7], digit_level[11],
  // overflow[12], zeros above
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [mssd_pkg::OUT_DAT_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tlast,
  // configuration writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mssd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mssd_pkg::CFG_DAT_W-1:0]     cfg_data_i
);
  import mssd_pkg::*;

  localparam logic [63:0] LIMIT64 = pow10_m1(MAX_DIGITS);
  localparam logic [NUM_W:0] LIMIT = (LIMIT64 > 64'(2**NUM_W - 1)) ?
                                     {1'b1, {NUM_W{1'b1}}} : LIMIT64[NUM_W:0];
  localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [SEL_W-1:0] MAXD = SEL_W'(MAX_DIGITS);

  state_e state_q, state_d;

  logic              cc_q;
  logic [SEL_W-1:0]  dc_q;
  logic              ovf_q, ovf_d;
  logic [SEL_W-1:0]  sel_q, sel_d;
  logic [SEL_W-1:0]  rem_q, rem_d;
  logic [SEL_W-1:0]  count;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_DAT_W-1:0]  out_data_q, out_data_d;
  logic                  out_last_q, out_last_d;
  logic                  out_load;

  logic                  in_acc;
  logic                  conv_start, conv_busy, conv_done;
  logic                  over;
  logic [NUM_W-1:0]      conv_value;
  digit_t [MAX_DIGITS-1:0] digits;
  digit_t                cur_digit;
  seg_t                  seg_lvl;

  mssd_dabble #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .value_i (conv_value),
    .busy_o  (conv_busy),
    .done_o  (conv_done),
    .digits_o(digits)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign count         = (dc_q > MAXD) ? MAXD : dc_q;

  // saturate before conversion
  assign over       = {1'b0, s_axis_tdata} > LIMIT;
  assign conv_value = over ? LIMIT[NUM_W-1:0] : s_axis_tdata;
  assign conv_start = in_acc && (s_axis_tuser == KIND_LOAD);

  // rem counts down the decimal power, most significant shown digit first
  assign cur_digit = digits[rem_q[IDX_W-1:0]];
  assign seg_lvl   = seg_of(cur_digit) ^ {7{~cc_q}};
  assign out_load  = (state_q == ST_SCAN) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d     = state_q;
    ovf_d       = ovf_q;
    sel_d       = sel_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == KIND_LOAD) begin
            ovf_d   = over;
            state_d = ST_CONV;
          end else if (count != '0) begin
            sel_d   = '0;
            rem_d   = count - SEL_W'(1);
            state_d = ST_SCAN;
          end
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_data_d  = {3'b000, ovf_q, ~cc_q, sel_q, seg_lvl};
          out_last_d  = (rem_q == '0);
          sel_d       = sel_q + SEL_W'(1);
          rem_d       = rem_q - SEL_W'(1);
          if (rem_q == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ovf_q       <= 1'b0;
      sel_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ovf_q       <= ovf_d;
      sel_q       <= sel_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q <= 1'b1;
      dc_q <= SEL_W'(4);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_COMMON_CATHODE: cc_q <= cfg_data_i[0];
        CFG_DIGIT_COUNT:    dc_q <= cfg_data_i[SEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  a_conv_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_busy |-> (state_q == ST_CONV)) else $error("converter busy outside conversion");

  a_scan_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |->
      (({1'b0, sel_q} + {1'b0, rem_q} + 5'd1) == {1'b0, count}))
    else $error("scan counters out of step");

  a_empty_refresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (s_axis_tuser == KIND_REFRESH) && (count == '0)) |=> (state_q == ST_IDLE))
    else $error("empty refresh did not return to idle");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_start |=> (conv_busy && (state_q == ST_CONV)))
    else $error("load request did not start conversion");

endmodule
